// ----- rtl/urbm_pkg.sv -----
`timescale 1ns / 1ps

package urbm_pkg;

   // Fixed field widths
   localparam int DATA_W     = 8;
   localparam int MODE_W     = 2;
   localparam int CAP_W      = 8;
   localparam int DCOUNT_W   = 3;
   localparam int DBYTES_W   = 32;
   localparam int FILL_W     = 8;

   // Ring size and index arithmetic run at this width (capacity + 1 up to 256)
   localparam int SIZE_W     = CAP_W + 1;

   // Delimiter bytes held in the delimiter register
   localparam int DELIM_SLOTS = DBYTES_W / DATA_W;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_COUNT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_BYTES  = 2'd3;

   // Operation codes
   localparam logic [MODE_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [MODE_W-1:0] OP_POP   = 2'd1;
   localparam logic [MODE_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [MODE_W-1:0] OP_ARM   = 2'd3;

   // Queue between front and back, and on the result side (power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Remainder unit: one dividend bit per step
   localparam int MOD_STEP_W  = 4;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] data_byte;
      logic [DATA_W-1:0] count;
      logic              delimiter_hit;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              read_valid;
      logic              no_data;
      logic              delimiter_hit;
      logic              count_reached;
      logic              overflow;
      logic [FILL_W-1:0] fill_level;
   } rsp_type;

   typedef struct packed {
      logic              enable;
      logic [SIZE_W-1:0] ring_size;
      logic              clear_index;
   } back_cfg_type;

endpackage

// ----- rtl/uart_rx_ring_buffer_with_match.sv -----
`timescale 1ns / 1ps
// Receive byte ring of a serial port with delimiter match and count alarm.
// Command channel: present req_mode / req_data_byte / req_count with push;
// a beat is taken when push is high and full is low. Modes: push byte,
// pop byte, clear ring, arm count target.
// Result channel: the oldest result sits on rsp_* while empty is low and is
// taken when pop is high. Exactly one result beat per command beat.
// Configuration: csr_write_enable with csr_index / csr_write_data writes one
// register in that cycle; write only while no command is in flight.
// Flow: a push, pop or clear taken into the command queue is executed by
// the back end and then reported into the result queue; an arm also waits
// on the bit-serial remainder that computes the target modulo the ring size.
// The back end takes a new command only after the last one is reported.
// A two-entry queue sits on each side, so commands keep being taken while
// results wait. When the receiver stalls, results and then commands back
// up and full rises; nothing is lost.
// Reset clears indices, the target and both queues; ring contents stay
// undefined until written. Registers reset to capacity 20, all else zero.
module uart_rx_ring_buffer_with_match
   import urbm_pkg::*;
#(
   parameter int RING_DEPTH     = 256,
   parameter int MAX_DELIMITERS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [DATA_W-1:0]    req_data_byte,
   input  logic [DATA_W-1:0]    req_count,
   output logic                 empty,
   input  logic                 pop,
   output logic [DATA_W-1:0]    rsp_read_data,
   output logic                 rsp_read_valid,
   output logic                 rsp_no_data,
   output logic                 rsp_delimiter_hit,
   output logic                 rsp_count_reached,
   output logic                 rsp_overflow,
   output logic [FILL_W-1:0]    rsp_fill_level,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DBYTES_W-1:0]  csr_write_data
);

   logic                enable_ff;
   logic [CAP_W-1:0]    capacity_ff;
   logic [DCOUNT_W-1:0] dcount_ff;
   logic [DBYTES_W-1:0] dbytes_ff;

   back_cfg_type        back_cfg;
   cmd_type             cmd_head;
   logic                cmd_empty, cmd_pop;
   rsp_type             rsp_new, rsp_head;
   logic                rsp_push, rsp_full;
   logic [SIZE_W-1:0]   cap_plus;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         capacity_ff <= CAP_W'(20);
         dcount_ff   <= '0;
         dbytes_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE:      enable_ff   <= csr_write_data[0];
            CSR_CAPACITY:    capacity_ff <= csr_write_data[CAP_W-1:0];
            CSR_DELIM_COUNT: dcount_ff   <= csr_write_data[DCOUNT_W-1:0];
            default:         dbytes_ff   <= csr_write_data;
         endcase
      end
   end

   // Ring size, limited to the storage depth
   assign cap_plus = {1'b0, capacity_ff} + 1'b1;

   always_comb begin
      back_cfg.enable      = enable_ff;
      back_cfg.ring_size   = (cap_plus > SIZE_W'(RING_DEPTH)) ? SIZE_W'(RING_DEPTH) : cap_plus;
      back_cfg.clear_index = csr_write_enable
                             && ((csr_index == CSR_CAPACITY)
                                 || ((csr_index == CSR_ENABLE)
                                     && csr_write_data[0] && !enable_ff));
   end

   urbm_front #(
      .MAX_DELIMITERS (MAX_DELIMITERS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .mode            (req_mode),
      .data_byte       (req_data_byte),
      .count           (req_count),
      .delimiter_count (dcount_ff),
      .delimiter_bytes (dbytes_ff),
      .cmd_pop         (cmd_pop),
      .cmd_head        (cmd_head),
      .cmd_empty       (cmd_empty)
   );

   urbm_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (back_cfg),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_out   (rsp_new),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   urbm_queue #(
      .WIDTH ($bits(rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_bits),
      .empty     (empty)
   );

   assign rsp_head          = rsp_type'(rsp_bits);
   assign rsp_read_data     = rsp_head.read_data;
   assign rsp_read_valid    = rsp_head.read_valid;
   assign rsp_no_data       = rsp_head.no_data;
   assign rsp_delimiter_hit = rsp_head.delimiter_hit;
   assign rsp_count_reached = rsp_head.count_reached;
   assign rsp_overflow      = rsp_head.overflow;
   assign rsp_fill_level    = rsp_head.fill_level;

endmodule

// ----- rtl/urbm_queue.sv -----
`timescale 1ns / 1ps

module urbm_queue
   import urbm_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers; depth is a power of two so they wrap on their own
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/urbm_front.sv -----
`timescale 1ns / 1ps

module urbm_front
   import urbm_pkg::*;
#(
   parameter int MAX_DELIMITERS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [MODE_W-1:0]   mode,
   input  logic [DATA_W-1:0]   data_byte,
   input  logic [DATA_W-1:0]   count,
   input  logic [DCOUNT_W-1:0] delimiter_count,
   input  logic [DBYTES_W-1:0] delimiter_bytes,
   input  logic                cmd_pop,
   output cmd_type             cmd_head,
   output logic                cmd_empty
);

   localparam int USED_DELIMS = (MAX_DELIMITERS < DELIM_SLOTS) ? MAX_DELIMITERS : DELIM_SLOTS;

   cmd_type             cmd_new;
   logic                hit;
   logic [$bits(cmd_type)-1:0] head_bits;

   // Match the byte against each delimiter slot in use
   always_comb begin
      hit = 1'b0;
      for (int k = 0; k < USED_DELIMS; k++) begin
         if ((DCOUNT_W'(k) < delimiter_count)
             && (delimiter_bytes[k*DATA_W +: DATA_W] == data_byte)) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      cmd_new.mode          = mode;
      cmd_new.data_byte     = data_byte;
      cmd_new.count         = count;
      cmd_new.delimiter_hit = hit;
   end

   urbm_queue #(
      .WIDTH ($bits(cmd_type))
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd_new),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (head_bits),
      .empty     (cmd_empty)
   );

   assign cmd_head = cmd_type'(head_bits);

endmodule

// ----- rtl/urbm_mod.sv -----
`timescale 1ns / 1ps

module urbm_mod
   import urbm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SIZE_W-1:0] dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              done,
   output logic [SIZE_W-1:0] remainder
);

   logic [SIZE_W-1:0]     quo_ff, quo_in;
   logic [SIZE_W-1:0]     rem_ff, rem_in;
   logic [MOD_STEP_W-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SIZE_W:0]       trial;

   assign trial     = {rem_ff, quo_ff[SIZE_W-1]};
   assign done      = done_ff;
   assign remainder = rem_ff;

   // Restoring remainder, one dividend bit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SIZE_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = SIZE_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[SIZE_W-1:0];
         end
         step_in = step_ff + 1'b1;
         if (step_ff == MOD_STEP_W'(SIZE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

// ----- rtl/urbm_back.sv -----
`timescale 1ns / 1ps

module urbm_back
   import urbm_pkg::*;
#(
   parameter int RING_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  back_cfg_type cfg,
   input  cmd_type      cmd_head,
   input  logic         cmd_empty,
   output logic         cmd_pop,
   output rsp_type      rsp_out,
   output logic         rsp_push,
   input  logic         rsp_full
);

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int PAD_W = SIZE_W - IDX_W;

   localparam logic [1:0] ST_EXEC = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  target_ff, target_in;
   logic              armed_ff, armed_in;
   rsp_type           flags_ff, flags_in;

   logic [DATA_W-1:0] ring_mem [RING_DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic              mem_we, mem_re;

   logic [SIZE_W-1:0] wr9, rd9, wr_plus9, rd_plus9, fill9;
   logic [IDX_W-1:0]  wr_next, rd_next;
   logic              mod_start, mod_done;
   logic [SIZE_W-1:0] mod_rem;

   assign wr9      = {{PAD_W{1'b0}}, wr_idx_ff};
   assign rd9      = {{PAD_W{1'b0}}, rd_idx_ff};
   assign wr_plus9 = wr9 + 1'b1;
   assign rd_plus9 = rd9 + 1'b1;
   assign wr_next  = (wr_plus9 == cfg.ring_size) ? '0 : wr_plus9[IDX_W-1:0];
   assign rd_next  = (rd_plus9 == cfg.ring_size) ? '0 : rd_plus9[IDX_W-1:0];
   assign fill9    = (rd_idx_ff > wr_idx_ff) ? SIZE_W'(cfg.ring_size - rd9 + wr9)
                                             : SIZE_W'(wr9 - rd9);

   urbm_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (SIZE_W'(wr9 + {1'b0, cmd_head.count})),
      .divisor   (cfg.ring_size),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Execute one operation, then report it
   always_comb begin
      state_in  = state_ff;
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      target_in = target_ff;
      armed_in  = armed_ff;
      flags_in  = flags_ff;
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mod_start = 1'b0;
      rsp_push  = 1'b0;
      rsp_out   = flags_ff;
      rsp_out.read_data  = flags_ff.read_valid ? rdata_ff : '0;
      rsp_out.fill_level = fill9[FILL_W-1:0];
      case (state_ff)
         ST_EXEC: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               flags_in = '0;
               state_in = ST_RESP;
               case (cmd_head.mode)
                  OP_PUSH: begin
                     if (cfg.enable) begin
                        flags_in.delimiter_hit = cmd_head.delimiter_hit;
                        if (wr_next != rd_idx_ff) begin
                           mem_we    = 1'b1;
                           wr_idx_in = wr_next;
                           if (armed_ff && (wr_next == target_ff)) begin
                              armed_in               = 1'b0;
                              flags_in.count_reached = 1'b1;
                           end
                        end else begin
                           flags_in.overflow = 1'b1;
                        end
                     end
                  end
                  OP_POP: begin
                     if (rd_idx_ff != wr_idx_ff) begin
                        mem_re              = 1'b1;
                        rd_idx_in           = rd_next;
                        flags_in.read_valid = 1'b1;
                     end else begin
                        flags_in.no_data = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     rd_idx_in = wr_idx_ff;
                  end
                  default: begin
                     mod_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (mod_done) begin
               target_in = mod_rem[IDX_W-1:0];
               armed_in  = 1'b1;
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_EXEC;
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
      // Return indices to zero on a capacity write or enable rising
      if (cfg.clear_index) begin
         wr_idx_in = '0;
         rd_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_EXEC;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         target_ff <= '0;
         armed_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         target_ff <= target_in;
         armed_ff  <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
   end

   // Ring storage with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_idx_ff] <= cmd_head.data_byte;
      end
      if (mem_re) begin
         rdata_ff <= ring_mem[rd_idx_ff];
      end
   end

endmodule
